// ----- rtl/core/plid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and codes for the positional list insert/delete block.
// ----------------------------------------------------------------------------
package plid_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_DISPLAY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SHOW = 1'b1
    } t_state;

    typedef enum logic [2:0] {
        SEL_HOLD  = 3'd0,
        SEL_NEW   = 3'd1,
        SEL_LEFT  = 3'd2,
        SEL_RIGHT = 3'd3,
        SEL_HEAD  = 3'd4
    } t_cell_sel;

    localparam int POS_BITS = 5;
    localparam int VAL_BITS = 32;

endpackage

// ----- rtl/core/positional_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of up to DEPTH words kept in a row of cells, with clear,
// insert and delete at a 1-based position, and display of all entries.
//
//   channel  dir  tdata                    tuser            tlast
//   s_axis   in   position[4:0] value[36:5] operation[1:0]   -
//   m_axis   out  value_out[31:0]          status[1:0]      last
//
// Clear, insert and delete are applied as the transfer is taken; every cell picks its next word
// in parallel from itself, a neighbor or the new word.
// Display of N entries: the transfer is taken, then the first N cells rotate
// one place a cycle toward cell 0 while the output is not stalled; cell 0 is
// read out at each step, and the order is restored at the end.
// Reset clears the count and the control state; cell contents are kept.
// A stalled output holds the block; one result register sits at the output.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
    import plid_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[4:0], value[36:5], zero pad
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // value_out[31:0]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    output logic        m_axis_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;

    logic                  r_out_valid;
    logic [VAL_BITS-1:0]   r_out_data;
    t_status               r_out_status;
    logic                  r_out_last;

    t_op                   w_op;
    logic [POS_BITS-1:0]   w_pos;
    logic [VAL_BITS-1:0]   w_value;
    logic                  w_slot_free;
    logic                  w_in_fire;
    logic                  w_show_step;
    logic                  w_emit;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_p0;
    logic [CMP_W-1:0]      w_cnt_x;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_ok;
    logic                  w_del_ok;
    logic [WORD_BITS-1:0]  w_new;
    logic [WORD_BITS-1:0]  w_word [DEPTH];
    logic [WORD_BITS-1:0]  w_pick;
    logic [VAL_BITS-1:0]   w_pick32;
    logic [VAL_BITS-1:0]   w_res_data;
    t_status               w_res_status;
    logic                  w_res_last;

    assign w_op    = t_op'(s_axis_tuser);
    assign w_pos   = s_axis_tdata[POS_BITS-1:0];
    assign w_value = s_axis_tdata[POS_BITS+VAL_BITS-1:POS_BITS];

    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_in_fire   = s_axis_tvalid && s_axis_tready;

    assign w_pos_x  = CMP_W'(w_pos);
    assign w_p0     = w_pos_x - CMP_W'(1);
    assign w_cnt_x  = CMP_W'(r_count);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_ins_ok = !w_full && (w_pos_x != '0) && (w_pos_x <= w_cnt_x + CMP_W'(1));
    assign w_del_ok = !w_empty && (w_pos_x != '0) && (w_pos_x <= w_cnt_x);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && w_op == OP_DISPLAY && !w_empty) begin
                    n_state = S_SHOW;
                end
            end
            S_SHOW: begin
                if (w_slot_free && r_left == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_show_step   = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = w_slot_free;
            S_SHOW:  w_show_step   = w_slot_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    generate
        if (WORD_BITS <= VAL_BITS) begin : g_narrow
            assign w_new    = w_value[WORD_BITS-1:0];
            assign w_pick32 = VAL_BITS'(w_pick);
        end else begin : g_wide
            assign w_new    = {{(WORD_BITS-VAL_BITS){w_value[VAL_BITS-1]}}, w_value};
            assign w_pick32 = w_pick[VAL_BITS-1:0];
        end
    endgenerate

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            localparam logic [CMP_W-1:0] L_IDX = CMP_W'(k);
            localparam logic [CMP_W-1:0] L_NXT = CMP_W'(k + 1);
            t_cell_sel            w_sel;
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;

            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_word[k-1];
            end
            if (k == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_word[k+1];
            end

            always_comb begin
                w_sel = SEL_HOLD;
                if (w_in_fire && w_op == OP_INSERT && w_ins_ok) begin
                    if (L_IDX == w_p0) begin
                        w_sel = SEL_NEW;
                    end else if (L_IDX > w_p0 && L_IDX <= w_cnt_x) begin
                        w_sel = SEL_LEFT;
                    end
                end else if (w_in_fire && w_op == OP_DELETE && w_del_ok) begin
                    if (L_IDX >= w_p0 && L_NXT < w_cnt_x) begin
                        w_sel = SEL_RIGHT;
                    end
                end else if (w_show_step) begin
                    if (L_NXT < w_cnt_x) begin
                        w_sel = SEL_RIGHT;
                    end else if (L_NXT == w_cnt_x) begin
                        w_sel = SEL_HEAD;
                    end
                end
            end

            plid_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_sel   (w_sel),
                .i_new   (w_new),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_word[0]),
                .o_word  (w_word[k])
            );
        end
    endgenerate

    assign w_pick = w_show_step ? w_word[0] : w_word[w_p0[IDX_W-1:0]];

    always_comb begin
        w_emit       = 1'b0;
        w_res_data   = '0;
        w_res_status = ST_OK;
        w_res_last   = 1'b1;
        if (w_show_step) begin
            w_emit     = 1'b1;
            w_res_data = w_pick32;
            w_res_last = (r_left == CNT_W'(1));
        end else if (w_in_fire) begin
            w_emit = 1'b1;
            case (w_op)
                OP_CLEAR: w_res_status = ST_OK;
                OP_INSERT: begin
                    if (w_full) begin
                        w_res_status = ST_FULL;
                    end else if (!w_ins_ok) begin
                        w_res_status = ST_BAD_POS;
                    end
                end
                OP_DELETE: begin
                    if (w_empty) begin
                        w_res_status = ST_EMPTY;
                    end else if (!w_del_ok) begin
                        w_res_status = ST_BAD_POS;
                    end else begin
                        w_res_data = w_pick32;
                    end
                end
                default: begin
                    if (w_empty) begin
                        w_res_status = ST_EMPTY;
                    end else begin
                        w_emit = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        if (w_in_fire) begin
            case (w_op)
                OP_CLEAR:   n_count = '0;
                OP_INSERT:  if (w_ins_ok) n_count = r_count + CNT_W'(1);
                OP_DELETE:  if (w_del_ok) n_count = r_count - CNT_W'(1);
                default:    n_left  = r_count;
            endcase
        end else if (w_show_step) begin
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data   <= w_res_data;
            r_out_status <= w_res_status;
            r_out_last   <= w_res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_show_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> (r_left != '0 && r_left <= r_count && !s_axis_tready))
        else $error("display counter out of range");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_op == OP_INSERT && w_ins_ok) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_show_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW && w_slot_free && r_left == CNT_W'(1)) |=>
            (r_state == S_IDLE && m_axis_tvalid && m_axis_tlast))
        else $error("display did not end on a marked transfer");
`endif

endmodule

// ----- rtl/core/plid_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds a word, or loads the new word, a neighbor's word or
// the head word, as the decoded select says.
// ----------------------------------------------------------------------------
module plid_cell
    import plid_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  t_cell_sel            i_sel,
    input  logic [WORD_BITS-1:0] i_new,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    input  logic [WORD_BITS-1:0] i_head,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        unique case (i_sel)
            SEL_NEW:   n_word = i_new;
            SEL_LEFT:  n_word = i_left;
            SEL_RIGHT: n_word = i_right;
            SEL_HEAD:  n_word = i_head;
            default:   n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
